[rtl/tpib_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the two priority input buffer.
// Depends on nothing; every other file of the block imports it.
package tpib_pkg;

  localparam int HIGH_DEPTH_DEF = 1024;
  localparam int LOW_DEPTH_DEF  = 1024;
  localparam int DESC_WIDTH_DEF = 32;

  localparam int CAP_W      = 11;
  localparam int CNT_W      = 11;
  localparam int STATUS_W   = 3;
  localparam int CLASS_W    = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_CAP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_CAP  = 1'd1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CLASS_W-1:0] CLS_NORMAL      = 2'd0;
  localparam logic [CLASS_W-1:0] CLS_RESUBMIT    = 2'd1;
  localparam logic [CLASS_W-1:0] CLS_RECIRCULATE = 2'd2;
  localparam logic [CLASS_W-1:0] CLS_SENTINEL    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RETRY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic accept;
  } tpib_cmd_t;

endpackage

[rtl/tpib_queue.sv]
`timescale 1ns / 1ps
// Ring buffer of descriptors with a configurable entry limit and a registered read port.
// Depends on tpib_pkg.
module tpib_queue #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tpib_pkg::CAP_W-1:0]    cap,
  input  logic                          push,
  input  logic [DW-1:0]                 push_data,
  input  logic                          pop,
  output logic                          full,
  output logic                          empty,
  output logic [$clog2(DEPTH+1)-1:0]    fill,
  output logic [DW-1:0]                 rd_data
);
  import tpib_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  logic [DW-1:0]     mem [DEPTH];
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [DW-1:0]     rd_data_r;
  logic [CMP_W-1:0]  fill_x, cap_x, depth_x;

  always_comb begin
    fill_x  = CMP_W'(fill_r);
    cap_x   = CMP_W'(cap);
    depth_x = CMP_W'(DEPTH);
    full    = (fill_x >= depth_x) || (fill_x >= cap_x);
    empty   = (fill_r == '0);
  end

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (push) begin
      tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (pop) begin
      head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail_r] <= push_data;
    end
    if (pop) begin
      rd_data_r <= mem[head_r];
    end
  end

  assign fill    = fill_r;
  assign rd_data = rd_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("queue fill exceeds depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full && !pop)
    else $error("push into full queue or together with pop");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> fill_r == $past(fill_r) - FILL_W'(1))
    else $error("fill did not drop after pop");

endmodule

[rtl/tpib_dpath.sv]
`timescale 1ns / 1ps
// Datapath: capacity registers, the two descriptor queues, the request decode and result registers.
// Depends on tpib_pkg and tpib_queue.
module tpib_dpath #(
  parameter int HIGH_DEPTH = 1024,
  parameter int LOW_DEPTH  = 1024,
  parameter int DESC_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tpib_pkg::tpib_cmd_t                cmd,
  input  logic                               cfg_we,
  input  logic [tpib_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpib_pkg::CAP_W-1:0]         cfg_data,
  input  logic                               in_op,
  input  logic [tpib_pkg::CLASS_W-1:0]       in_packet_class,
  input  logic [DESC_WIDTH-1:0]              in_descriptor,
  output logic [tpib_pkg::STATUS_W-1:0]      out_status,
  output logic [DESC_WIDTH-1:0]              out_descriptor,
  output logic                               out_from_high,
  output logic [tpib_pkg::CNT_W-1:0]         out_high_count,
  output logic [tpib_pkg::CNT_W-1:0]         out_low_count
);
  import tpib_pkg::*;

  localparam int HFILL_W = $clog2(HIGH_DEPTH + 1);
  localparam int LFILL_W = $clog2(LOW_DEPTH + 1);

  logic [CAP_W-1:0]    high_cap_r, high_cap_nxt;
  logic [CAP_W-1:0]    low_cap_r, low_cap_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                from_high_r, from_high_nxt;

  logic                high_push, high_pop, high_full, high_empty;
  logic                low_push, low_pop, low_full, low_empty;
  logic [HFILL_W-1:0]  high_fill;
  logic [LFILL_W-1:0]  low_fill;
  logic [DESC_WIDTH-1:0] high_rd, low_rd;

  always_comb begin
    high_cap_nxt = high_cap_r;
    low_cap_nxt  = low_cap_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_CAP: high_cap_nxt = cfg_data;
        REG_LOW_CAP:  low_cap_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    high_push     = 1'b0;
    high_pop      = 1'b0;
    low_push      = 1'b0;
    low_pop       = 1'b0;
    status_nxt    = status_r;
    from_high_nxt = from_high_r;
    if (cmd.accept) begin
      from_high_nxt = 1'b0;
      if (in_op == OP_PUSH) begin
        if (in_packet_class == CLS_NORMAL) begin
          if (low_full) begin
            status_nxt = ST_RETRY;
          end else begin
            low_push   = 1'b1;
            status_nxt = ST_ACCEPTED;
          end
        end else if (high_full) begin
          status_nxt = (in_packet_class == CLS_SENTINEL) ? ST_RETRY : ST_DROPPED;
        end else begin
          high_push  = 1'b1;
          status_nxt = ST_ACCEPTED;
        end
      end else if (!high_empty) begin
        high_pop      = 1'b1;
        from_high_nxt = 1'b1;
        status_nxt    = ST_POPPED;
      end else if (!low_empty) begin
        low_pop    = 1'b1;
        status_nxt = ST_POPPED;
      end else begin
        status_nxt = ST_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_cap_r  <= CAP_RESET;
      low_cap_r   <= CAP_RESET;
      status_r    <= ST_EMPTY;
      from_high_r <= 1'b0;
    end else begin
      high_cap_r  <= high_cap_nxt;
      low_cap_r   <= low_cap_nxt;
      status_r    <= status_nxt;
      from_high_r <= from_high_nxt;
    end
  end

  tpib_queue #(
    .DEPTH (HIGH_DEPTH),
    .DW    (DESC_WIDTH)
  ) u_high_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (high_cap_r),
    .push      (high_push),
    .push_data (in_descriptor),
    .pop       (high_pop),
    .full      (high_full),
    .empty     (high_empty),
    .fill      (high_fill),
    .rd_data   (high_rd)
  );

  tpib_queue #(
    .DEPTH (LOW_DEPTH),
    .DW    (DESC_WIDTH)
  ) u_low_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap       (low_cap_r),
    .push      (low_push),
    .push_data (in_descriptor),
    .pop       (low_pop),
    .full      (low_full),
    .empty     (low_empty),
    .fill      (low_fill),
    .rd_data   (low_rd)
  );

  always_comb begin
    out_status     = status_r;
    out_from_high  = from_high_r;
    out_high_count = CNT_W'(high_fill);
    out_low_count  = CNT_W'(low_fill);
    if (status_r == ST_POPPED) begin
      out_descriptor = from_high_r ? high_rd : low_rd;
    end else begin
      out_descriptor = '0;
    end
  end

endmodule

[rtl/tpib_ctrl.sv]
`timescale 1ns / 1ps
// Controller: request handshake and result hold state machine.
// Depends on tpib_pkg.
module tpib_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tpib_pkg::tpib_cmd_t  cmd
);
  import tpib_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign in_ready   = rst_n && ((state_r == S_IDLE) || out_ready);
  assign out_valid  = (state_r == S_HOLD);
  assign accept     = in_valid && in_ready;
  assign cmd.accept = accept;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept) begin
          state_nxt = S_HOLD;
        end else if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !accept)
    else $error("request accepted over a waiting result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !accept |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

[rtl/two_priority_input_buffer.sv]
`timescale 1ns / 1ps
// Strict priority dual descriptor queue: one request per accepted input, one result per request.
// A request accepted at one clock edge shows its result in the next cycle; when the result is
// taken at once, a new request is accepted every cycle. A pop reads the registered memory port
// of the serving queue at acceptance, and that read data is the result. The descriptor stores
// need no clearing after reset, so the block takes requests from the first cycle out of reset.
// Depends on tpib_pkg, tpib_ctrl, tpib_dpath and tpib_queue.
module two_priority_input_buffer #(
  parameter int HIGH_DEPTH = tpib_pkg::HIGH_DEPTH_DEF,
  parameter int LOW_DEPTH  = tpib_pkg::LOW_DEPTH_DEF,
  parameter int DESC_WIDTH = tpib_pkg::DESC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [tpib_pkg::CLASS_W-1:0]   in_packet_class,
  input  logic [DESC_WIDTH-1:0]          in_descriptor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tpib_pkg::STATUS_W-1:0]  out_status,
  output logic [DESC_WIDTH-1:0]          out_descriptor,
  output logic                           out_from_high,
  output logic [tpib_pkg::CNT_W-1:0]     out_high_count,
  output logic [tpib_pkg::CNT_W-1:0]     out_low_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpib_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tpib_pkg::CAP_W-1:0]     cfg_data
);
  import tpib_pkg::*;

  tpib_cmd_t cmd;

  assign cfg_ready = rst_n;

  tpib_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tpib_dpath #(
    .HIGH_DEPTH (HIGH_DEPTH),
    .LOW_DEPTH  (LOW_DEPTH),
    .DESC_WIDTH (DESC_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_packet_class (in_packet_class),
    .in_descriptor   (in_descriptor),
    .out_status      (out_status),
    .out_descriptor  (out_descriptor),
    .out_from_high   (out_from_high),
    .out_high_count  (out_high_count),
    .out_low_count   (out_low_count)
  );

endmodule

[dv/tb_two_priority_input_buffer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for two_priority_input_buffer: directed, bulk-fill and random traffic.
// Expected results come from a queue-based predictor in this file; depends on tpib_pkg and the RTL.
module tb_two_priority_input_buffer;
  import tpib_pkg::*;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [31:0]         desc;
    logic                from_high;
    logic [CNT_W-1:0]    high_count;
    logic [CNT_W-1:0]    low_count;
  } buf_result_t;

  class dual_queue_tracker;
    logic [31:0] high_ring[$];
    logic [31:0] low_ring[$];
    int unsigned high_cap = 1024;
    int unsigned low_cap = 1024;
    buf_result_t owed_results[$];
    int unsigned mismatches = 0;

    function void set_capacity(logic [CFG_IDX_W-1:0] idx, logic [CAP_W-1:0] value);
      case (idx)
        REG_HIGH_CAP: high_cap = 32'(value);
        REG_LOW_CAP: low_cap = 32'(value);
        default: ;
      endcase
    endfunction

    function void note_request(logic op, logic [CLASS_W-1:0] cls, logic [31:0] desc);
      buf_result_t r;
      int unsigned high_lim;
      int unsigned low_lim;
      high_lim = (high_cap > HIGH_DEPTH_DEF) ? HIGH_DEPTH_DEF : high_cap;
      low_lim = (low_cap > LOW_DEPTH_DEF) ? LOW_DEPTH_DEF : low_cap;
      r.desc = '0;
      r.from_high = 1'b0;
      if (op == OP_PUSH) begin
        if (cls == CLS_NORMAL) begin
          if (low_ring.size() >= low_lim) begin
            r.status = ST_RETRY;
          end else begin
            low_ring.insert(low_ring.size(), desc);
            r.status = ST_ACCEPTED;
          end
        end else if (high_ring.size() >= high_lim) begin
          r.status = (cls == CLS_SENTINEL) ? ST_RETRY : ST_DROPPED;
        end else begin
          high_ring.insert(high_ring.size(), desc);
          r.status = ST_ACCEPTED;
        end
      end else if (high_ring.size() != 0) begin
        r.desc = high_ring.pop_front();
        r.from_high = 1'b1;
        r.status = ST_POPPED;
      end else if (low_ring.size() != 0) begin
        r.desc = low_ring.pop_front();
        r.status = ST_POPPED;
      end else begin
        r.status = ST_EMPTY;
      end
      r.high_count = CNT_W'(high_ring.size());
      r.low_count = CNT_W'(low_ring.size());
      owed_results.insert(owed_results.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(buf_result_t got);
      buf_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with status %0d arrived with no request outstanding", got.status);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_descriptor", want.desc, got.desc);
      compare_field("from_high", 32'(want.from_high), 32'(got.from_high));
      compare_field("high_count", 32'(want.high_count), 32'(got.high_count));
      compare_field("low_count", 32'(want.low_count), 32'(got.low_count));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_PUSH;
  logic [CLASS_W-1:0] in_packet_class = CLS_NORMAL;
  logic [31:0] in_descriptor = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [31:0] out_descriptor;
  logic out_from_high;
  logic [CNT_W-1:0] out_high_count;
  logic [CNT_W-1:0] out_low_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HIGH_CAP;
  logic [CAP_W-1:0] cfg_data = '0;

  dual_queue_tracker tracker = new();
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 19;
  int unsigned hold_off_req = 0;

  two_priority_input_buffer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_packet_class(in_packet_class),
    .in_descriptor(in_descriptor),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_descriptor(out_descriptor),
    .out_from_high(out_from_high),
    .out_high_count(out_high_count),
    .out_low_count(out_low_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin : result_sink
    buf_result_t seen;
    int unsigned stall_left;
    int unsigned hold_off_done;
    stall_left = 0;
    hold_off_done = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        seen.status = out_status;
        seen.desc = out_descriptor;
        seen.from_high = out_from_high;
        seen.high_count = out_high_count;
        seen.low_count = out_low_count;
        tracker.check_response(seen);
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_off_done != hold_off_req) begin
        hold_off_done = hold_off_req;
        stall_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(input logic op, input logic [CLASS_W-1:0] cls,
                              input logic [31:0] desc);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_packet_class <= cls;
    in_descriptor <= desc;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, cls, desc);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (tracker.owed_results.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_capacity(idx, value);
  endtask

  function automatic logic [CAP_W-1:0] pick_capacity();
    case ($urandom_range(9))
      0: return '0;
      1: return CAP_W'(1);
      2: return '1;
      3: return CAP_W'(1024);
      4: return CAP_W'($urandom_range(1025, 2047));
      default: return CAP_W'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin : stimulus
    logic op;
    logic [CLASS_W-1:0] cls;
    logic [31:0] desc;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(REG_HIGH_CAP, CAP_RESET);
    write_reg(REG_LOW_CAP, CAP_RESET);

    send_request(OP_POP, CLS_NORMAL, 32'h0);
    send_request(OP_PUSH, CLS_NORMAL, 32'h0000_0000);
    send_request(OP_PUSH, CLS_NORMAL, 32'hFFFF_FFFF);
    send_request(OP_PUSH, CLS_RESUBMIT, 32'hA5A5_A5A5);
    send_request(OP_PUSH, CLS_RECIRCULATE, 32'h5A5A_5A5A);
    send_request(OP_PUSH, CLS_SENTINEL, 32'h1234_5678);
    send_request(OP_POP, CLS_SENTINEL, 32'hFFFF_FFFF);
    send_request(OP_POP, CLS_NORMAL, 32'h0);
    wait_drained();

    // The low limit now sits below the current occupancy, the high limit one above it.
    write_reg(REG_HIGH_CAP, CAP_W'(2));
    write_reg(REG_LOW_CAP, CAP_W'(1));
    send_request(OP_PUSH, CLS_NORMAL, 32'h0BAD_F00D);
    send_request(OP_PUSH, CLS_RESUBMIT, 32'hC001_D00D);
    send_request(OP_PUSH, CLS_RECIRCULATE, 32'hDEAD_0001);
    send_request(OP_PUSH, CLS_SENTINEL, 32'hDEAD_0002);
    repeat (5) send_request(OP_POP, CLS_NORMAL, 32'h0);
    wait_drained();

    write_reg(REG_HIGH_CAP, '0);
    write_reg(REG_LOW_CAP, '0);
    send_request(OP_PUSH, CLS_NORMAL, 32'h1111_1111);
    send_request(OP_PUSH, CLS_RESUBMIT, 32'h2222_2222);
    send_request(OP_PUSH, CLS_RECIRCULATE, 32'h3333_3333);
    send_request(OP_PUSH, CLS_SENTINEL, 32'h4444_4444);
    send_request(OP_POP, CLS_NORMAL, 32'h0);
    wait_drained();

    // Fill the low ring to its full depth without idling; the request past it is refused.
    write_reg(REG_HIGH_CAP, CAP_W'(1024));
    write_reg(REG_LOW_CAP, '1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 1025; i++) begin
      send_request(OP_PUSH, CLS_NORMAL, $urandom);
    end
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        write_reg(REG_HIGH_CAP, CAP_W'(4));
        write_reg(REG_LOW_CAP, CAP_W'(4));
      end else begin
        write_reg(REG_HIGH_CAP, pick_capacity());
        write_reg(REG_LOW_CAP, pick_capacity());
      end
      tx_idle_pct = (phase == 2) ? 0 : 19;
      rx_idle_pct = (phase == 2) ? 0 : 19;
      if (phase == 3) hold_off_req++;
      for (int i = 0; i < 28; i++) begin
        op = ($urandom_range(99) < 45) ? OP_POP : OP_PUSH;
        cls = CLASS_W'($urandom_range(3));
        case ($urandom_range(15))
          0: desc = '0;
          1: desc = '1;
          default: desc = $urandom;
        endcase
        send_request(op, cls, desc);
      end
      wait_drained();
    end

    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("tb_two_priority_input_buffer: clean");
    end else begin
      $display("tb_two_priority_input_buffer: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb_two_priority_input_buffer: errors");
    $finish;
  end

endmodule
